// ===== src/carlson_rc_integral_defines.svh =====
// Assertion macros for the Carlson RC block.
`ifndef CARLSON_RC_INTEGRAL_DEFINES_SVH
`define CARLSON_RC_INTEGRAL_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define CRC_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("crc assertion failed");
`define CRC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("crc assertion failed");
`else
`define CRC_ASSERT_NOW(lbl, ante, cons)
`define CRC_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ===== src/crc_pkg.sv =====
package crc_pkg;

    typedef struct packed {
        logic [31:0] x_bits;
        logic [31:0] y_bits;
    } in_t;

    typedef struct packed {
        logic [31:0] rc_bits;
        logic        no_convergence;
    } out_t;

    typedef enum logic [1:0] {
        OP_ADD,
        OP_MUL,
        OP_DIV,
        OP_SQRT
    } fpu_op_t;

    typedef struct packed {
        logic        start;
        fpu_op_t     op;
        logic [31:0] a;
        logic [31:0] b;
    } fpu_req_t;

    typedef enum logic [4:0] {
        SRC_X, SRC_Y, SRC_MU, SRC_SN, SRC_T, SRC_SX, SRC_LAM, SRC_S,
        SRC_THIRD, SRC_NEG2, SRC_TWO, SRC_QUARTER, SRC_NINE22, SRC_C3,
        SRC_SEVENTH, SRC_C4, SRC_ONE
    } src_t;

    typedef enum logic [2:0] {
        DST_X, DST_Y, DST_MU, DST_SN, DST_T, DST_SX, DST_LAM, DST_S
    } dst_t;

    typedef struct packed {
        fpu_op_t op;
        src_t    src_a;
        src_t    src_b;
        dst_t    dst;
    } micro_t;

    localparam int MW = 50;

    localparam logic [31:0] QNAN      = 32'h7FC0_0000;
    localparam logic [31:0] K_THIRD   = 32'h3EAA_AAAB;
    localparam logic [31:0] K_NEG2    = 32'hC000_0000;
    localparam logic [31:0] K_TWO     = 32'h4000_0000;
    localparam logic [31:0] K_QUARTER = 32'h3E80_0000;
    localparam logic [31:0] K_NINE22  = 32'h3ED1_745D;
    localparam logic [31:0] K_C3      = 32'h3EC0_0000;
    localparam logic [31:0] K_SEVENTH = 32'h3E12_4925;
    localparam logic [31:0] K_C4      = 32'h3E99_999A;
    localparam logic [31:0] K_ONE     = 32'h3F80_0000;
    localparam logic [31:0] TOL_RESET = 32'h3A83_126F;

    localparam logic [4:0] STEP_TEST    = 5'd5;
    localparam logic [4:0] STEP_DUP     = 5'd6;
    localparam logic [4:0] STEP_DUP_END = 5'd14;
    localparam logic [4:0] STEP_SERIES  = 5'd15;
    localparam logic [4:0] STEP_END     = 5'd25;

    function automatic micro_t micro(input logic [4:0] step);
        micro_t m;
        case (step)
            5'd0:  m = '{OP_ADD,  SRC_Y,   SRC_Y,       DST_T};
            5'd1:  m = '{OP_ADD,  SRC_X,   SRC_T,       DST_T};
            5'd2:  m = '{OP_MUL,  SRC_T,   SRC_THIRD,   DST_MU};
            5'd3:  m = '{OP_ADD,  SRC_Y,   SRC_MU,      DST_T};
            5'd4:  m = '{OP_DIV,  SRC_T,   SRC_MU,      DST_SN};
            5'd5:  m = '{OP_ADD,  SRC_SN,  SRC_NEG2,    DST_SN};
            5'd6:  m = '{OP_SQRT, SRC_X,   SRC_X,       DST_SX};
            5'd7:  m = '{OP_SQRT, SRC_Y,   SRC_Y,       DST_T};
            5'd8:  m = '{OP_MUL,  SRC_TWO, SRC_SX,      DST_LAM};
            5'd9:  m = '{OP_MUL,  SRC_LAM, SRC_T,       DST_LAM};
            5'd10: m = '{OP_ADD,  SRC_LAM, SRC_Y,       DST_LAM};
            5'd11: m = '{OP_ADD,  SRC_X,   SRC_LAM,     DST_T};
            5'd12: m = '{OP_MUL,  SRC_T,   SRC_QUARTER, DST_X};
            5'd13: m = '{OP_ADD,  SRC_Y,   SRC_LAM,     DST_T};
            5'd14: m = '{OP_MUL,  SRC_T,   SRC_QUARTER, DST_Y};
            5'd15: m = '{OP_MUL,  SRC_SN,  SRC_NINE22,  DST_T};
            5'd16: m = '{OP_ADD,  SRC_T,   SRC_C3,      DST_T};
            5'd17: m = '{OP_MUL,  SRC_T,   SRC_SN,      DST_T};
            5'd18: m = '{OP_ADD,  SRC_T,   SRC_SEVENTH, DST_T};
            5'd19: m = '{OP_MUL,  SRC_T,   SRC_SN,      DST_T};
            5'd20: m = '{OP_ADD,  SRC_T,   SRC_C4,      DST_T};
            5'd21: m = '{OP_MUL,  SRC_SN,  SRC_SN,      DST_S};
            5'd22: m = '{OP_MUL,  SRC_S,   SRC_T,       DST_S};
            5'd23: m = '{OP_ADD,  SRC_ONE, SRC_S,       DST_S};
            5'd24: m = '{OP_SQRT, SRC_MU,  SRC_MU,      DST_T};
            5'd25: m = '{OP_DIV,  SRC_S,   SRC_T,       DST_S};
            default: m = '{OP_ADD, SRC_T,  SRC_T,       DST_T};
        endcase
        return m;
    endfunction

endpackage

// ===== src/crc_fpu.sv =====
module crc_fpu (
    input  logic              clk,
    input  logic              rst_n,
    input  crc_pkg::fpu_req_t req,
    output logic              done,
    output logic [31:0]       y
);

    typedef enum logic [2:0] {
        F_IDLE, F_PRE, F_DIV, F_SQRT, F_NORM, F_RSH, F_ROUND
    } fstate_t;

    fstate_t          state_reg;
    crc_pkg::fpu_op_t op_reg;
    logic             sign_reg;
    logic [23:0]      ma_reg;
    logic [23:0]      mb_reg;
    logic signed [11:0] ea_reg;
    logic signed [11:0] eb_reg;
    logic [49:0]      mant_reg;
    logic signed [11:0] exp_reg;
    logic             sticky_reg;
    logic [27:0]      rem_reg;
    logic [49:0]      q_reg;
    logic [51:0]      rad_reg;
    logic [5:0]       cnt_reg;
    logic             done_reg;
    logic [31:0]      y_reg;

    // operand unpack
    logic        sa, sb;
    logic [7:0]  bea, beb;
    logic        a_zero, b_zero, a_inf, b_inf, a_nan, b_nan;
    logic [23:0] ma, mb;
    logic signed [11:0] ea, eb;

    assign sa     = req.a[31];
    assign sb     = req.b[31];
    assign bea    = req.a[30:23];
    assign beb    = req.b[30:23];
    assign a_zero = (req.a[30:0] == 31'd0);
    assign b_zero = (req.b[30:0] == 31'd0);
    assign a_inf  = (bea == 8'hFF) && (req.a[22:0] == 23'd0);
    assign b_inf  = (beb == 8'hFF) && (req.b[22:0] == 23'd0);
    assign a_nan  = (bea == 8'hFF) && (req.a[22:0] != 23'd0);
    assign b_nan  = (beb == 8'hFF) && (req.b[22:0] != 23'd0);
    assign ma     = {bea != 8'd0, req.a[22:0]};
    assign mb     = {beb != 8'd0, req.b[22:0]};
    assign ea     = $signed({4'd0, (bea == 8'd0) ? 8'd1 : bea}) - 12'sd150;
    assign eb     = $signed({4'd0, (beb == 8'd0) ? 8'd1 : beb}) - 12'sd150;

    // special operands
    logic        spec_hit;
    logic [31:0] spec_val;
    logic        sx;

    assign sx = sa ^ sb;

    always_comb
    begin
        spec_hit = 1'b1;
        spec_val = crc_pkg::QNAN;
        case (req.op)
            crc_pkg::OP_ADD:
            begin
                if (a_nan || b_nan || (a_inf && b_inf && (sa != sb)))
                    spec_val = crc_pkg::QNAN;
                else if (a_inf)
                    spec_val = req.a;
                else if (b_inf)
                    spec_val = req.b;
                else if (a_zero && b_zero)
                    spec_val = {sa & sb, 31'd0};
                else if (a_zero)
                    spec_val = req.b;
                else if (b_zero)
                    spec_val = req.a;
                else
                    spec_hit = 1'b0;
            end
            crc_pkg::OP_MUL:
            begin
                if (a_nan || b_nan || (a_inf && b_zero) || (a_zero && b_inf))
                    spec_val = crc_pkg::QNAN;
                else if (a_inf || b_inf)
                    spec_val = {sx, 31'h7F80_0000};
                else if (a_zero || b_zero)
                    spec_val = {sx, 31'd0};
                else
                    spec_hit = 1'b0;
            end
            crc_pkg::OP_DIV:
            begin
                if (a_nan || b_nan || (a_inf && b_inf) || (a_zero && b_zero))
                    spec_val = crc_pkg::QNAN;
                else if (a_inf || b_zero)
                    spec_val = {sx, 31'h7F80_0000};
                else if (a_zero || b_inf)
                    spec_val = {sx, 31'd0};
                else
                    spec_hit = 1'b0;
            end
            crc_pkg::OP_SQRT:
            begin
                if (a_nan || (sa && !a_zero))
                    spec_val = crc_pkg::QNAN;
                else if (a_zero || a_inf)
                    spec_val = req.a;
                else
                    spec_hit = 1'b0;
            end
            default: spec_hit = 1'b1;
        endcase
    end

    // add alignment
    logic        a_ge;
    logic [31:0] opl, ops;
    logic [7:0]  bel, bes, dsh;
    logic [23:0] ml, ms;
    logic [49:0] afull, bfull, bsh, bj, sum;
    logic        bst;
    logic signed [11:0] add_exp;

    always_comb
    begin
        a_ge  = req.a[30:0] >= req.b[30:0];
        opl   = a_ge ? req.a : req.b;
        ops   = a_ge ? req.b : req.a;
        bel   = (opl[30:23] == 8'd0) ? 8'd1 : opl[30:23];
        bes   = (ops[30:23] == 8'd0) ? 8'd1 : ops[30:23];
        dsh   = bel - bes;
        ml    = {opl[30:23] != 8'd0, opl[22:0]};
        ms    = {ops[30:23] != 8'd0, ops[22:0]};
        afull = {1'b0, ml, 25'd0};
        bfull = {1'b0, ms, 25'd0};
        if (dsh >= 8'd50)
        begin
            bsh = 50'd0;
            bst = |ms;
        end
        else
        begin
            bsh = bfull >> dsh;
            bst = |(bfull & ~({50{1'b1}} << dsh));
        end
        bj      = {bsh[49:1], bsh[0] | bst};
        sum     = (opl[31] ^ ops[31]) ? (afull - bj) : (afull + bj);
        add_exp = $signed({4'd0, bel}) - 12'sd175;
    end

    // division and square root steps
    logic [24:0] rem_div;
    logic        div_ge;
    logic [29:0] rem2;
    logic [29:0] trial;
    logic        sq_ge;

    assign rem_div = rem_reg[24:0];
    assign div_ge  = rem_div >= {1'b0, mb_reg};
    assign rem2    = {rem_reg, rad_reg[51:50]};
    assign trial   = {2'b00, q_reg[25:0], 2'b01};
    assign sq_ge   = rem2 >= trial;

    // rounding
    logic signed [11:0] be;
    logic [24:0] rnd;
    logic        rup;
    logic [34:0] mag;
    logic [11:0] bem1;

    always_comb
    begin
        be   = exp_reg + 12'sd176;
        bem1 = be - 12'sd1;
        rup  = mant_reg[25] & ((|mant_reg[24:0]) | sticky_reg | mant_reg[26]);
        rnd  = {1'b0, mant_reg[49:26]} + {24'd0, rup};
        mag  = {bem1, 23'd0} + {10'd0, rnd};
    end

    logic        sq_odd;
    logic [25:0] sq_m;
    logic signed [11:0] sq_e;
    logic [47:0] prod;

    assign sq_odd = ea_reg[0];
    assign sq_m   = sq_odd ? {1'b0, ma_reg, 1'b0} : {2'b00, ma_reg};
    assign sq_e   = sq_odd ? (ea_reg - 12'sd1) : ea_reg;
    assign prod   = ma_reg * mb_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                F_IDLE:
                begin
                    if (req.start)
                    begin
                        op_reg     <= req.op;
                        sticky_reg <= 1'b0;
                        ma_reg     <= ma;
                        mb_reg     <= mb;
                        ea_reg     <= ea;
                        eb_reg     <= eb;
                        sign_reg   <= (req.op == crc_pkg::OP_SQRT) ? 1'b0 :
                                      (req.op == crc_pkg::OP_ADD) ? opl[31] : sx;
                        if (spec_hit)
                        begin
                            y_reg    <= spec_val;
                            done_reg <= 1'b1;
                        end
                        else if (req.op == crc_pkg::OP_ADD)
                        begin
                            if (sum == 50'd0)
                            begin
                                y_reg    <= 32'd0;
                                done_reg <= 1'b1;
                            end
                            else
                            begin
                                mant_reg  <= sum;
                                exp_reg   <= add_exp;
                                state_reg <= F_NORM;
                            end
                        end
                        else
                            state_reg <= F_PRE;
                    end
                end
                F_PRE:
                begin
                    if (!ma_reg[23])
                    begin
                        ma_reg <= {ma_reg[22:0], 1'b0};
                        ea_reg <= ea_reg - 12'sd1;
                    end
                    if (!mb_reg[23] && (op_reg != crc_pkg::OP_SQRT))
                    begin
                        mb_reg <= {mb_reg[22:0], 1'b0};
                        eb_reg <= eb_reg - 12'sd1;
                    end
                    if (ma_reg[23] && (mb_reg[23] || (op_reg == crc_pkg::OP_SQRT)))
                    begin
                        case (op_reg)
                            crc_pkg::OP_MUL:
                            begin
                                mant_reg  <= {prod, 2'b00};
                                exp_reg   <= ea_reg + eb_reg - 12'sd2;
                                state_reg <= F_NORM;
                            end
                            crc_pkg::OP_DIV:
                            begin
                                rem_reg   <= {4'd0, ma_reg};
                                q_reg     <= 50'd0;
                                cnt_reg   <= 6'(crc_pkg::MW);
                                exp_reg   <= ea_reg - eb_reg - 12'(crc_pkg::MW - 1);
                                state_reg <= F_DIV;
                            end
                            default:
                            begin
                                rad_reg   <= {sq_m, 26'd0};
                                rem_reg   <= 28'd0;
                                q_reg     <= 50'd0;
                                cnt_reg   <= 6'd26;
                                exp_reg   <= ((sq_e - 12'sd26) >>> 1) - 12'sd24;
                                state_reg <= F_SQRT;
                            end
                        endcase
                    end
                end
                F_DIV:
                begin
                    if (cnt_reg == 6'd0)
                    begin
                        mant_reg  <= {q_reg[49:1], q_reg[0] | (rem_div != 25'd0)};
                        state_reg <= F_NORM;
                    end
                    else
                    begin
                        q_reg   <= {q_reg[48:0], div_ge};
                        rem_reg <= {2'd0, (div_ge ? (rem_div - {1'b0, mb_reg}) : rem_div),
                                    1'b0} ;
                        cnt_reg <= cnt_reg - 6'd1;
                    end
                end
                F_SQRT:
                begin
                    if (cnt_reg == 6'd0)
                    begin
                        mant_reg  <= {q_reg[25:0], 23'd0, rem_reg != 28'd0};
                        state_reg <= F_NORM;
                    end
                    else
                    begin
                        rad_reg <= {rad_reg[49:0], 2'b00};
                        rem_reg <= sq_ge ? 28'(rem2 - trial) : rem2[27:0];
                        q_reg   <= {q_reg[48:0], sq_ge};
                        cnt_reg <= cnt_reg - 6'd1;
                    end
                end
                F_NORM:
                begin
                    if (!mant_reg[49])
                    begin
                        mant_reg <= {mant_reg[48:0], 1'b0};
                        exp_reg  <= exp_reg - 12'sd1;
                    end
                    else if (be < 12'sd1)
                        state_reg <= F_RSH;
                    else
                        state_reg <= F_ROUND;
                end
                F_RSH:
                begin
                    if (be >= 12'sd1)
                        state_reg <= F_ROUND;
                    else if (mant_reg == 50'd0)
                        exp_reg <= -12'sd175;
                    else
                    begin
                        mant_reg   <= {1'b0, mant_reg[49:1]};
                        sticky_reg <= sticky_reg | mant_reg[0];
                        exp_reg    <= exp_reg + 12'sd1;
                    end
                end
                F_ROUND:
                begin
                    if (mag >= 35'h0_7F80_0000)
                        y_reg <= {sign_reg, 31'h7F80_0000};
                    else
                        y_reg <= {sign_reg, mag[30:0]};
                    done_reg  <= 1'b1;
                    state_reg <= F_IDLE;
                end
                default: state_reg <= F_IDLE;
            endcase
        end
    end

    assign done = done_reg;
    assign y    = y_reg;

endmodule

// ===== src/carlson_rc_integral.sv =====
// Run time is data dependent; each duplication pass runs 9 float operations, plus
// 6 for the convergence test and 11 for the series, on one shared float unit.
// Throughput: one word at a time; busy stays high until the result strobe.
// Reset: asynchronous active low; sequencer idle, tolerance back to 0.001.
`include "carlson_rc_integral_defines.svh"

module carlson_rc_integral #(
    parameter int MAX_ITER = 32
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    output logic          busy,
    input  crc_pkg::in_t  operands,
    output logic          result_valid,
    output crc_pkg::out_t result,
    input  logic          cfg_we,
    input  logic [30:0]   cfg_data
);

    localparam int CW = $clog2(MAX_ITER + 1);

    typedef enum logic [1:0] {
        S_IDLE, S_ISSUE, S_WAIT, S_CHECK
    } state_t;

    state_t       state_reg;
    logic [4:0]   step_reg;
    logic [CW-1:0] count_reg;
    logic [30:0]  tol_reg;
    logic         conv_reg;
    logic [31:0]  x_reg, y_reg, mu_reg, sn_reg, t_reg, sx_reg, lam_reg, s_reg;
    logic         valid_reg;
    crc_pkg::out_t result_reg;

    crc_pkg::micro_t  mc;
    crc_pkg::fpu_req_t req;
    logic             fpu_done;
    logic [31:0]      fpu_y;
    logic             conv;

    function automatic logic [31:0] pick(input crc_pkg::src_t s,
        input logic [31:0] x, input logic [31:0] yv, input logic [31:0] mu,
        input logic [31:0] sn, input logic [31:0] t, input logic [31:0] sxv,
        input logic [31:0] lam, input logic [31:0] sv);
        logic [31:0] r;
        case (s)
            crc_pkg::SRC_X:       r = x;
            crc_pkg::SRC_Y:       r = yv;
            crc_pkg::SRC_MU:      r = mu;
            crc_pkg::SRC_SN:      r = sn;
            crc_pkg::SRC_T:       r = t;
            crc_pkg::SRC_SX:      r = sxv;
            crc_pkg::SRC_LAM:     r = lam;
            crc_pkg::SRC_S:       r = sv;
            crc_pkg::SRC_THIRD:   r = crc_pkg::K_THIRD;
            crc_pkg::SRC_NEG2:    r = crc_pkg::K_NEG2;
            crc_pkg::SRC_TWO:     r = crc_pkg::K_TWO;
            crc_pkg::SRC_QUARTER: r = crc_pkg::K_QUARTER;
            crc_pkg::SRC_NINE22:  r = crc_pkg::K_NINE22;
            crc_pkg::SRC_C3:      r = crc_pkg::K_C3;
            crc_pkg::SRC_SEVENTH: r = crc_pkg::K_SEVENTH;
            crc_pkg::SRC_C4:      r = crc_pkg::K_C4;
            crc_pkg::SRC_ONE:     r = crc_pkg::K_ONE;
            default:              r = crc_pkg::K_ONE;
        endcase
        return r;
    endfunction

    assign mc = crc_pkg::micro(step_reg);

    always_comb
    begin
        req.start = (state_reg == S_ISSUE);
        req.op    = mc.op;
        req.a     = pick(mc.src_a, x_reg, y_reg, mu_reg, sn_reg, t_reg, sx_reg,
                         lam_reg, s_reg);
        req.b     = pick(mc.src_b, x_reg, y_reg, mu_reg, sn_reg, t_reg, sx_reg,
                         lam_reg, s_reg);
    end

    crc_fpu u_fpu (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .done  (fpu_done),
        .y     (fpu_y)
    );

    // |sn| < tol on the raw bits; a NaN compares above any legal bound
    assign conv = sn_reg[30:0] < tol_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            step_reg  <= 5'd0;
            count_reg <= '0;
            tol_reg   <= crc_pkg::TOL_RESET[30:0];
            conv_reg  <= 1'b0;
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= 1'b0;
            if (cfg_we)
                tol_reg <= cfg_data;
            case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        x_reg     <= operands.x_bits;
                        y_reg     <= operands.y_bits;
                        count_reg <= '0;
                        step_reg  <= 5'd0;
                        state_reg <= S_ISSUE;
                    end
                end
                S_ISSUE: state_reg <= S_WAIT;
                S_WAIT:
                begin
                    if (fpu_done)
                    begin
                        case (mc.dst)
                            crc_pkg::DST_X:   x_reg   <= fpu_y;
                            crc_pkg::DST_Y:   y_reg   <= fpu_y;
                            crc_pkg::DST_MU:  mu_reg  <= fpu_y;
                            crc_pkg::DST_SN:  sn_reg  <= fpu_y;
                            crc_pkg::DST_T:   t_reg   <= fpu_y;
                            crc_pkg::DST_SX:  sx_reg  <= fpu_y;
                            crc_pkg::DST_LAM: lam_reg <= fpu_y;
                            default:          s_reg   <= fpu_y;
                        endcase
                        if (step_reg == crc_pkg::STEP_TEST)
                            state_reg <= S_CHECK;
                        else if (step_reg == crc_pkg::STEP_DUP_END)
                        begin
                            count_reg <= count_reg + 1'b1;
                            step_reg  <= 5'd0;
                            state_reg <= S_ISSUE;
                        end
                        else if (step_reg == crc_pkg::STEP_END)
                        begin
                            result_reg.rc_bits        <= fpu_y;
                            result_reg.no_convergence <= !conv_reg;
                            valid_reg                 <= 1'b1;
                            state_reg                 <= S_IDLE;
                        end
                        else
                        begin
                            step_reg  <= step_reg + 5'd1;
                            state_reg <= S_ISSUE;
                        end
                    end
                end
                S_CHECK:
                begin
                    conv_reg <= conv;
                    if (conv || (count_reg >= CW'(MAX_ITER)))
                        step_reg <= crc_pkg::STEP_SERIES;
                    else
                        step_reg <= crc_pkg::STEP_DUP;
                    state_reg <= S_ISSUE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign busy         = (state_reg != S_IDLE);
    assign result_valid = valid_reg;
    assign result       = result_reg;

    `CRC_ASSERT_NOW(a_out_idle, result_valid, !busy)
    `CRC_ASSERT_NEXT(a_take_busy, start && !busy, busy)
    `CRC_ASSERT_NEXT(a_one_pulse, result_valid, !result_valid)
    `CRC_ASSERT_NOW(a_count_cap, busy, count_reg <= CW'(MAX_ITER))

endmodule
